### rtl/core/bcpe_pkg.sv
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared constants, register codes and the binomial table for the Bezier
// curve point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

  // fractional bits of t and of the Bernstein powers
  localparam int T_FRAC_BITS = 16;
  // width of the t_param port
  localparam int T_IN_W = 17;
  // width of a power or weight: values run from 0 to 1.0 inclusive
  localparam int PW = T_FRAC_BITS + 1;
  localparam logic [PW-1:0] ONE = PW'(1 << T_FRAC_BITS);

  // control point coordinates
  localparam int PT_BITS = 16;
  localparam int COORD_BITS = 16;
  localparam logic [PT_BITS-1:0] COORD_MASK = PT_BITS'((1 << COORD_BITS) - 1);
  localparam int ACC_W = PW + PT_BITS;

  // control point storage
  localparam int NUM_POINTS = 8;
  localparam int NUM_PREGS = 4;
  localparam int REG_W = 64;

  // curve order register
  localparam int ORD_W = 3;
  localparam logic [ORD_W-1:0] ORD_RESET = 3'd3;
  localparam int MAX_ORDER_DEF = 7;

  // configuration register index
  localparam int IDX_W = 3;
  typedef enum logic [IDX_W-1:0] {
    REG_CURVE_ORDER = 3'd0,
    REG_POINTS_0_1  = 3'd1,
    REG_POINTS_2_3  = 3'd2,
    REG_POINTS_4_5  = 3'd3,
    REG_POINTS_6_7  = 3'd4
  } cfg_reg_t;

  // binomial coefficients, rows of Pascal's triangle up to degree 7
  localparam int BW = 6;
  localparam logic [BW-1:0] BINOM [0:NUM_POINTS-1][0:NUM_POINTS-1] = '{
    '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
    '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
    '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
  };

endpackage

### rtl/core/bcpe_power_chain.sv
// ----------------------------------------------------------------------------
// bcpe_power_chain
// Input register with clamping of t, then one stage per power that forms
// t^k and (1-t)^k in Q1.16, truncated after every product.
// ----------------------------------------------------------------------------
module bcpe_power_chain #(
  parameter int MAX_ORDER = bcpe_pkg::MAX_ORDER_DEF,
  localparam int NORD = (MAX_ORDER > bcpe_pkg::NUM_POINTS - 1) ?
                        bcpe_pkg::NUM_POINTS - 1 : MAX_ORDER
) (
  input  logic                      clk,
  input  logic [NORD:0]             en,
  input  logic [bcpe_pkg::T_IN_W-1:0] t_param,
  output logic [bcpe_pkg::PW-1:0]   tp_pow [0:NORD],
  output logic [bcpe_pkg::PW-1:0]   mp_pow [0:NORD]
);

  localparam int PW = bcpe_pkg::PW;
  localparam int TF = bcpe_pkg::T_FRAC_BITS;

  logic [PW-1:0] t_s  [0:NORD-1];
  logic [PW-1:0] m_s  [0:NORD-1];
  logic [PW-1:0] tp_s [0:NORD][0:NORD];
  logic [PW-1:0] mp_s [0:NORD][0:NORD];
  logic [PW-1:0] t_clamp;

  // t above one saturates to exactly one
  assign t_clamp = (t_param > bcpe_pkg::T_IN_W'(bcpe_pkg::ONE)) ?
                   bcpe_pkg::ONE : PW'(t_param);

  // stage 0: register t and 1-t, every power starts at one
  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_s[0] <= t_clamp;
      m_s[0] <= bcpe_pkg::ONE - t_clamp;
      for (int j = 0; j <= NORD; j++) begin
        tp_s[0][j] <= bcpe_pkg::ONE;
        mp_s[0][j] <= bcpe_pkg::ONE;
      end
    end
  end

  // stage k: power k from power k-1
  for (genvar k = 1; k <= NORD; k++) begin : g_pow
    logic [2*PW-1:0] tprod;
    logic [2*PW-1:0] mprod;

    assign tprod = tp_s[k-1][k-1] * t_s[k-1];
    assign mprod = mp_s[k-1][k-1] * m_s[k-1];

    always_ff @(posedge clk) begin
      if (en[k]) begin
        for (int j = 0; j <= NORD; j++) begin
          if (j == k) begin
            tp_s[k][j] <= tprod[TF+PW-1:TF];
            mp_s[k][j] <= mprod[TF+PW-1:TF];
          end else begin
            tp_s[k][j] <= tp_s[k-1][j];
            mp_s[k][j] <= mp_s[k-1][j];
          end
        end
      end
    end

    // carry t and 1-t while later powers still need them
    if (k < NORD) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          t_s[k] <= t_s[k-1];
          m_s[k] <= m_s[k-1];
        end
      end
    end
  end

  for (genvar j = 0; j <= NORD; j++) begin : g_out
    assign tp_pow[j] = tp_s[NORD][j];
    assign mp_pow[j] = mp_s[NORD][j];
  end

endmodule

### rtl/core/bcpe_weight.sv
// ----------------------------------------------------------------------------
// bcpe_weight
// Two stages that turn the powers into Bernstein weights:
// (1-t)^(n-i) * t^i, then scaled by the binomial C(n,i) and truncated.
// ----------------------------------------------------------------------------
module bcpe_weight #(
  parameter int MAX_ORDER = bcpe_pkg::MAX_ORDER_DEF,
  localparam int NORD = (MAX_ORDER > bcpe_pkg::NUM_POINTS - 1) ?
                        bcpe_pkg::NUM_POINTS - 1 : MAX_ORDER
) (
  input  logic                       clk,
  input  logic [1:0]                 en,
  input  logic [bcpe_pkg::ORD_W-1:0] n_eff,
  input  logic [bcpe_pkg::PW-1:0]    tp_pow [0:NORD],
  input  logic [bcpe_pkg::PW-1:0]    mp_pow [0:NORD],
  output logic [bcpe_pkg::PW-1:0]    weight [0:NORD]
);

  localparam int PW = bcpe_pkg::PW;
  localparam int TF = bcpe_pkg::T_FRAC_BITS;
  localparam int BW = bcpe_pkg::BW;
  localparam int IW = (NORD > 1) ? $clog2(NORD + 1) : 1;

  logic [2*PW-1:0] prod_r [0:NORD];

  for (genvar i = 0; i <= NORD; i++) begin : g_lane
    logic [IW-1:0]       sel;
    logic [BW+2*PW-1:0]  bprod;

    // lanes past the order get a zero binomial, so their select is free
    assign sel = (n_eff >= bcpe_pkg::ORD_W'(i)) ?
                 IW'(n_eff - bcpe_pkg::ORD_W'(i)) : '0;

    // stage A: product of the two powers
    always_ff @(posedge clk) begin
      if (en[0]) begin
        prod_r[i] <= tp_pow[i] * mp_pow[sel];
      end
    end

    // stage B: binomial scale and truncation
    assign bprod = bcpe_pkg::BINOM[n_eff][i] * prod_r[i];

    always_ff @(posedge clk) begin
      if (en[1]) begin
        weight[i] <= bprod[TF+PW-1:TF];
      end
    end
  end

endmodule

### rtl/core/bcpe_accum.sv
// ----------------------------------------------------------------------------
// bcpe_accum
// Weighted sum of the control points: one multiply stage per lane, a
// pair-sum stage, and a final sum stage that truncates to integer coordinates.
// ----------------------------------------------------------------------------
module bcpe_accum #(
  parameter int MAX_ORDER = bcpe_pkg::MAX_ORDER_DEF,
  localparam int NORD = (MAX_ORDER > bcpe_pkg::NUM_POINTS - 1) ?
                        bcpe_pkg::NUM_POINTS - 1 : MAX_ORDER
) (
  input  logic                         clk,
  input  logic [2:0]                   en,
  input  logic [bcpe_pkg::PW-1:0]      weight [0:NORD],
  input  logic [bcpe_pkg::REG_W-1:0]   pts [0:bcpe_pkg::NUM_PREGS-1],
  output logic [bcpe_pkg::PT_BITS-1:0] point_x,
  output logic [bcpe_pkg::PT_BITS-1:0] point_y
);

  localparam int AW = bcpe_pkg::ACC_W;
  localparam int PB = bcpe_pkg::PT_BITS;
  localparam int TF = bcpe_pkg::T_FRAC_BITS;
  localparam int NP = (NORD + 2) / 2;

  logic [AW-1:0] mx_r [0:NORD];
  logic [AW-1:0] my_r [0:NORD];
  logic [AW-1:0] sx_r [0:NP-1];
  logic [AW-1:0] sy_r [0:NP-1];
  logic [AW-1:0] acc_x;
  logic [AW-1:0] acc_y;

  // stage A: weight times each coordinate of its control point
  for (genvar i = 0; i <= NORD; i++) begin : g_mul
    logic [PB-1:0] px;
    logic [PB-1:0] py;

    assign px = pts[i/2][(i%2)*32 +: PB];
    assign py = pts[i/2][(i%2)*32 + PB +: PB];

    always_ff @(posedge clk) begin
      if (en[0]) begin
        mx_r[i] <= weight[i] * px;
        my_r[i] <= weight[i] * py;
      end
    end
  end

  // stage B: sums of neighboring lanes
  for (genvar p = 0; p < NP; p++) begin : g_pair
    if (2*p + 1 <= NORD) begin : g_two
      always_ff @(posedge clk) begin
        if (en[1]) begin
          sx_r[p] <= mx_r[2*p] + mx_r[2*p+1];
          sy_r[p] <= my_r[2*p] + my_r[2*p+1];
        end
      end
    end else begin : g_one
      always_ff @(posedge clk) begin
        if (en[1]) begin
          sx_r[p] <= mx_r[2*p];
          sy_r[p] <= my_r[2*p];
        end
      end
    end
  end

  // stage C: total and drop the fraction
  always_comb begin
    acc_x = '0;
    acc_y = '0;
    for (int p = 0; p < NP; p++) begin
      acc_x = acc_x + sx_r[p];
      acc_y = acc_y + sy_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      point_x <= acc_x[TF+PB-1:TF] & bcpe_pkg::COORD_MASK;
      point_y <= acc_y[TF+PB-1:TF] & bcpe_pkg::COORD_MASK;
    end
  end

endmodule

### rtl/core/bezier_curve_point_eval_unit.sv
// ----------------------------------------------------------------------------
// bezier_curve_point_eval_unit
// Bernstein-form Bezier curve point evaluator, one point per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Write curve_order (index 0) and the packed control points (indexes 1..4)
//   on the cfg channel while no item is in flight; cfg_ready is always high.
//   Each item on the in channel is a curve parameter t_param in Q1.16 (65536
//   is 1.0, larger values clamp to 1.0). The out channel returns one item
//   per input, point_x and point_y, truncated to integers, in input order.
// Pipeline: an input register, then the t^k / (1-t)^k power chain with one
//   multiply per stage up to power NORD (MAX_ORDER capped at 7), then the
//   weight and accumulate stages.
// Throughput: one item per cycle while the output is not stalled; every stage holds its own valid bit.
// Stall: while out_ready is low the pipeline keeps filling its empty stages;
//   in_ready drops only once every stage holds an item.
// Reset: rst clears all valid bits, sets curve_order to 3 and all control
//   points to zero.
// ----------------------------------------------------------------------------
module bezier_curve_point_eval_unit #(
  parameter int MAX_ORDER = bcpe_pkg::MAX_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bcpe_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bcpe_pkg::REG_W-1:0]   cfg_data,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bcpe_pkg::T_IN_W-1:0]  t_param,
  // result items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bcpe_pkg::PT_BITS-1:0] point_x,
  output logic [bcpe_pkg::PT_BITS-1:0] point_y
);

  localparam int NORD = (MAX_ORDER > bcpe_pkg::NUM_POINTS - 1) ?
                        bcpe_pkg::NUM_POINTS - 1 : MAX_ORDER;
  localparam int NS = NORD + 6;
  localparam int PW = bcpe_pkg::PW;

  logic [bcpe_pkg::ORD_W-1:0] curve_order;
  logic [bcpe_pkg::REG_W-1:0] pts [0:bcpe_pkg::NUM_PREGS-1];
  logic [bcpe_pkg::ORD_W-1:0] n_eff;
  logic [NS-1:0]              v;
  logic [NS:0]                en;
  logic [PW-1:0]              tp_pow [0:NORD];
  logic [PW-1:0]              mp_pow [0:NORD];
  logic [PW-1:0]              weight [0:NORD];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= bcpe_pkg::ORD_RESET;
      for (int r = 0; r < bcpe_pkg::NUM_PREGS; r++) begin
        pts[r] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bcpe_pkg::REG_CURVE_ORDER: curve_order <= cfg_data[bcpe_pkg::ORD_W-1:0];
        bcpe_pkg::REG_POINTS_0_1:  pts[0] <= cfg_data;
        bcpe_pkg::REG_POINTS_2_3:  pts[1] <= cfg_data;
        bcpe_pkg::REG_POINTS_4_5:  pts[2] <= cfg_data;
        bcpe_pkg::REG_POINTS_6_7:  pts[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // order limited to what the datapath holds
  assign n_eff = (curve_order > bcpe_pkg::ORD_W'(NORD)) ?
                 bcpe_pkg::ORD_W'(NORD) : curve_order;

  // stage enables: a stage loads when it is empty or its item moves on
  assign en[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  // datapath
  bcpe_power_chain #(.MAX_ORDER(MAX_ORDER)) u_pow (
    .clk     (clk),
    .en      (en[NORD:0]),
    .t_param (t_param),
    .tp_pow  (tp_pow),
    .mp_pow  (mp_pow)
  );

  bcpe_weight #(.MAX_ORDER(MAX_ORDER)) u_wgt (
    .clk    (clk),
    .en     (en[NORD+2:NORD+1]),
    .n_eff  (n_eff),
    .tp_pow (tp_pow),
    .mp_pow (mp_pow),
    .weight (weight)
  );

  bcpe_accum #(.MAX_ORDER(MAX_ORDER)) u_acc (
    .clk     (clk),
    .en      (en[NORD+5:NORD+3]),
    .weight  (weight),
    .pts     (pts),
    .point_x (point_x),
    .point_y (point_y)
  );

`ifndef ASSERT_OFF
  // pipeline is empty from the cycle after rst is sampled
  a_reset_empty: assert property (@(posedge clk) rst |=> v == '0)
    else $error("valid bits set after reset");

  // input is refused only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ((&v) && !out_ready))
    else $error("input refused with room in the pipeline");

  // an accepted item with no delivery adds exactly one occupied stage
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready))
    |=> $countones(v) == $past($countones(v)) + 1)
    else $error("item lost or duplicated in pipeline");

  // a delivery with no new item frees exactly one stage
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!(in_valid && in_ready) && out_valid && out_ready)
    |=> $countones(v) + 1 == $past($countones(v)))
    else $error("item lost or duplicated in pipeline");
`endif

endmodule

### sim/bcpe_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpe_point_checker
// Watches the cfg, in and out channels of the Bezier point evaluator. Keeps
// its own copy of the curve registers, works out the Bernstein point for each
// accepted t and compares it with the results in arrival order.
// ----------------------------------------------------------------------------
module bcpe_point_checker
  import bcpe_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [T_IN_W-1:0]  t_param,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [PT_BITS-1:0] point_x,
  input  logic [PT_BITS-1:0] point_y,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  localparam longint unsigned T_ONE = 64'd1 << T_FRAC_BITS;

  typedef struct packed {
    logic [PT_BITS-1:0] x;
    logic [PT_BITS-1:0] y;
  } curve_pt_t;

  // shadow copy of the curve registers
  logic [ORD_W-1:0] order_q;
  logic [REG_W-1:0] pts_q [0:NUM_PREGS-1];

  // points still owed by the block, oldest first
  curve_pt_t point_q [$];

  // binomial coefficient by the multiplicative formula
  function automatic longint unsigned pascal(input int n, input int k);
    longint unsigned c;
    c = 1;
    for (int j = 0; j < k; j++) c = c * longint'(n - j) / longint'(j + 1);
    return c;
  endfunction

  // Bernstein sum in Q1.16, the powers truncated after every product
  function automatic curve_pt_t bezier_point(input logic [T_IN_W-1:0] t_in);
    longint unsigned tv;
    longint unsigned mv;
    longint unsigned w;
    longint unsigned acc_x;
    longint unsigned acc_y;
    longint unsigned tpow [0:NUM_POINTS-1];
    longint unsigned mpow [0:NUM_POINTS-1];
    logic [31:0] pt;
    int deg;
    curve_pt_t res;
    tv = 64'(t_in);
    // t above one clamps to exactly one
    if (tv > T_ONE) tv = T_ONE;
    mv = T_ONE - tv;
    // degree limited by the parameter and by the eight point slots
    deg = int'(order_q);
    if (deg > MAX_ORDER) deg = MAX_ORDER;
    if (deg > NUM_POINTS - 1) deg = NUM_POINTS - 1;
    tpow[0] = T_ONE;
    mpow[0] = T_ONE;
    for (int i = 1; i <= deg; i++) begin
      tpow[i] = (tpow[i-1] * tv) >> T_FRAC_BITS;
      mpow[i] = (mpow[i-1] * mv) >> T_FRAC_BITS;
    end
    acc_x = 0;
    acc_y = 0;
    for (int i = 0; i <= deg; i++) begin
      w = (pascal(deg, i) * mpow[deg-i] * tpow[i]) >> T_FRAC_BITS;
      pt = pts_q[i/2][(i%2)*32 +: 32];
      acc_x += w * 64'(pt[15:0]);
      acc_y += w * 64'(pt[31:16]);
    end
    res.x = PT_BITS'(acc_x >> T_FRAC_BITS);
    res.y = PT_BITS'(acc_y >> T_FRAC_BITS);
    return res;
  endfunction

  always @(posedge clk) begin
    curve_pt_t want;
    if (rst) begin
      order_q = ORD_RESET;
      for (int r = 0; r < NUM_PREGS; r++) pts_q[r] = '0;
      point_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      // register writes, unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CURVE_ORDER: order_q = cfg_data[ORD_W-1:0];
          REG_POINTS_0_1:  pts_q[0] = cfg_data;
          REG_POINTS_2_3:  pts_q[1] = cfg_data;
          REG_POINTS_4_5:  pts_q[2] = cfg_data;
          REG_POINTS_6_7:  pts_q[3] = cfg_data;
          default: ;
        endcase
      end
      // result item against the oldest prediction
      if (out_valid && out_ready) begin
        if (point_q.size() == 0) begin
          $display("%0t: unexpected point, expected none, got x=%0d y=%0d",
                   $time, point_x, point_y);
          fail_count++;
        end else begin
          want = point_q.pop_front();
          checked++;
          if (point_x !== want.x) begin
            $display("%0t: point_x mismatch, expected %0d, got %0d",
                     $time, want.x, point_x);
            fail_count++;
          end
          if (point_y !== want.y) begin
            $display("%0t: point_y mismatch, expected %0d, got %0d",
                     $time, want.y, point_y);
            fail_count++;
          end
        end
      end
      // input item, predicted with the registers as they stand
      if (in_valid && in_ready) point_q.insert(point_q.size(), bezier_point(t_param));
    end
    pending = point_q.size();
  end

endmodule

### sim/bezier_curve_point_eval_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_curve_point_eval_unit_tb
// Drives t values and curve register writes into the Bezier point evaluator
// under several idle and stall patterns, including a long output hold-off,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module bezier_curve_point_eval_unit_tb;
  import bcpe_pkg::*;

  localparam int MAX_ORDER      = MAX_ORDER_DEF;
  localparam int DRAIN_PAD      = MAX_ORDER + 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 118;
  localparam int HOLD_ITEMS     = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [REG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [T_IN_W-1:0]  t_param = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PT_BITS-1:0] point_x;
  logic [PT_BITS-1:0] point_y;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int reg_writes = 0;
  int src_idle = 0;
  int snk_stall = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bezier_curve_point_eval_unit #(
    .MAX_ORDER(MAX_ORDER)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .t_param   (t_param),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y)
  );

  bcpe_point_checker #(
    .MAX_ORDER(MAX_ORDER)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .t_param    (t_param),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= snk_stall);
    end
  end

  // watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
          (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d points outstanding", $time, pending);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // idle pattern: 0 none, 1 sender, 2 receiver, 3 both
  task automatic set_idle(input int mode);
    case (mode)
      0: begin src_idle = 0;  snk_stall = 0;  end
      1: begin src_idle = 49; snk_stall = 0;  end
      2: begin src_idle = 0;  snk_stall = 49; end
      default: begin src_idle = 28; snk_stall = 28; end
    endcase
  endtask

  // offer one t, valid stays high into the next item unless a gap is drawn
  task automatic send_item(input logic [T_IN_W-1:0] t);
    if (src_idle > 0 && $urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
    end
    in_valid <= 1'b1;
    t_param <= t;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // one register write, valid left high for a following write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  // stop offering items and wait for every owed point, then a latency pad
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // point register: mostly random, sometimes all ones or all zeros
  function automatic logic [REG_W-1:0] rand_points();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '1;
    if (sel == 1) return '0;
    return rand64();
  endfunction

  // random t: mostly inside [0, 1.0], with ends and over-range values
  function automatic logic [T_IN_W-1:0] rand_t();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) return '0;
    if (sel < 6) return T_IN_W'(ONE);
    if (sel < 8) return T_IN_W'(ONE - 1);
    if (sel < 10) return T_IN_W'(1);
    if (sel < 20) return T_IN_W'($urandom);
    return T_IN_W'($urandom_range(0, int'(ONE)));
  endfunction

  // full curve load, random upper bits in the order word, maybe a stray index
  task automatic load_curve(input int ord, input logic [REG_W-1:0] p01,
                            input logic [REG_W-1:0] p23, input logic [REG_W-1:0] p45,
                            input logic [REG_W-1:0] p67);
    logic [REG_W-1:0] ord_word;
    ord_word = rand64();
    ord_word[ORD_W-1:0] = ORD_W'(ord);
    write_reg(REG_CURVE_ORDER, ord_word);
    write_reg(REG_POINTS_0_1, p01);
    write_reg(REG_POINTS_2_3, p23);
    write_reg(REG_POINTS_4_5, p45);
    write_reg(REG_POINTS_6_7, p67);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(IDX_W'($urandom_range(int'(REG_POINTS_6_7) + 1, (1 << IDX_W) - 1)),
                rand64());
    end
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    int ord;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idle(0);

    // reset registers: cubic over all-zero points
    send_item('0);
    send_item(T_IN_W'(ONE));
    send_item(T_IN_W'(ONE >> 1));
    drain();

    // cubic, every coordinate at full scale, t at and past its ends
    load_curve(3, '1, '1, '1, '1);
    send_item('0);
    send_item(T_IN_W'(1));
    send_item(T_IN_W'(ONE >> 1));
    send_item(T_IN_W'(ONE - 1));
    send_item(T_IN_W'(ONE));
    send_item(T_IN_W'(ONE + 1));
    send_item('1);
    drain();

    // writes to indexes past the last register must change nothing
    for (int k = int'(REG_POINTS_6_7) + 1; k < (1 << IDX_W); k++) begin
      write_reg(IDX_W'(k), rand64());
    end
    cfg_valid <= 1'b0;
    @(posedge clk);

    // degree zero gives the first point for any t
    load_curve(0, rand64(), rand64(), rand64(), rand64());
    send_item('0);
    send_item(T_IN_W'(ONE));
    send_item(T_IN_W'(40000));
    drain();

    // highest degree
    load_curve(MAX_ORDER, rand64(), rand64(), rand64(), rand64());
    send_item('0);
    send_item(T_IN_W'(ONE));
    send_item(T_IN_W'(1));
    send_item(T_IN_W'(ONE - 1));
    send_item(T_IN_W'(21845));
    drain();

    // straight line
    load_curve(1, rand64(), rand64(), rand64(), rand64());
    send_item(T_IN_W'(ONE >> 1));
    send_item(T_IN_W'(ONE));
    drain();

    // random phases over every degree and idle pattern
    for (int p = 0; p < RAND_PHASES; p++) begin
      ord = (p < (1 << ORD_W)) ? p : $urandom_range(0, (1 << ORD_W) - 1);
      load_curve(ord, rand_points(), rand_points(), rand_points(), rand_points());
      set_idle(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_t());
      drain();

      // long receiver hold-off while the sender keeps offering
      if (p == RAND_PHASES / 2) begin
        set_idle(0);
        hold_req = 1'b1;
        for (int n = 0; n < HOLD_ITEMS; n++) send_item(rand_t());
        drain();
      end
    end

    $display("run covered %0d t values and %0d register writes, degrees 0 to %0d,",
             items_sent, reg_writes, (1 << ORD_W) - 1);
    $display("t over its whole 17-bit range; %0d points compared", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
